@@ rtl/lwr_pkg.sv @@
// Package for the link weight rescaler: sizes, payload structs, register codes,
// microcode word format and the microcode ROM. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lwr_pkg;

  localparam int NUM_LINKS  = 8;
  localparam int IDX_W      = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int LINK_W     = 3;
  localparam int BW_W       = 32;
  localparam int WEIGHT_W   = 11;
  localparam int CFG_W      = 10;
  localparam int CFG_ADDR_W = 1;
  localparam int PC_W       = 4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = '1;
  localparam logic [CFG_W-1:0]    MAX_WEIGHT_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0]    MIN_WEIGHT_RESET = CFG_W'(1);

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_WEIGHT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_WEIGHT = CFG_ADDR_W'(1);

  typedef struct packed {
    logic [LINK_W-1:0] link_index;
    logic [BW_W-1:0]   bandwidth;
  } lwr_request_t;

  typedef struct packed {
    logic [LINK_W-1:0]   out_link;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } lwr_result_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MAX,       // fold bandwidth[idx] into running maximum
    OP_DIV_TOP,   // start divider: max / scale
    OP_SETDIV,    // latch divisor, clamp zero to one
    OP_DIV_LINK,  // start divider: bandwidth[idx] / divisor
    OP_WSTORE,    // store fresh weight, track change
    OP_EMIT,      // emit one weight, commit it
    OP_END
  } lwr_op_t;

  typedef enum logic [1:0] {
    C_NEXT,       // fall through
    C_NOT_LAST,   // jump unless idx is the last link
    C_DIV_BUSY,   // jump while divider runs
    C_UNCHANGED   // jump when weight set is unchanged
  } lwr_cond_t;

  typedef struct packed {
    lwr_op_t         op;
    lwr_cond_t       cond;
    logic [PC_W-1:0] target;
  } lwr_uword_t;

  localparam logic [PC_W-1:0] PC_MAX      = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV_WAIT = PC_W'(2);
  localparam logic [PC_W-1:0] PC_DIV_LINK = PC_W'(4);
  localparam logic [PC_W-1:0] PC_LW_WAIT  = PC_W'(5);
  localparam logic [PC_W-1:0] PC_EMIT     = PC_W'(8);
  localparam logic [PC_W-1:0] PC_END      = PC_W'(9);

  function automatic lwr_uword_t ucode_rom(input logic [PC_W-1:0] pc);
    lwr_uword_t w;
    w = '{op: OP_END, cond: C_NEXT, target: PC_MAX};
    case (pc)
      PC_W'(0): w = '{op: OP_MAX,      cond: C_NOT_LAST,  target: PC_MAX};
      PC_W'(1): w = '{op: OP_DIV_TOP,  cond: C_NEXT,      target: PC_MAX};
      PC_W'(2): w = '{op: OP_NOP,      cond: C_DIV_BUSY,  target: PC_DIV_WAIT};
      PC_W'(3): w = '{op: OP_SETDIV,   cond: C_NEXT,      target: PC_MAX};
      PC_W'(4): w = '{op: OP_DIV_LINK, cond: C_NEXT,      target: PC_MAX};
      PC_W'(5): w = '{op: OP_NOP,      cond: C_DIV_BUSY,  target: PC_LW_WAIT};
      PC_W'(6): w = '{op: OP_WSTORE,   cond: C_NOT_LAST,  target: PC_DIV_LINK};
      PC_W'(7): w = '{op: OP_NOP,      cond: C_UNCHANGED, target: PC_END};
      PC_W'(8): w = '{op: OP_EMIT,     cond: C_NOT_LAST,  target: PC_EMIT};
      PC_W'(9): w = '{op: OP_END,      cond: C_NEXT,      target: PC_MAX};
      default:  w = '{op: OP_END,      cond: C_NEXT,      target: PC_MAX};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/link_weight_rescaler_core.sv @@
// Link weight rescaler top level: microcode sequencer, link tables, result port.
// Depends on lwr_pkg and lwr_divider.
//
// Usage:
//   Request channel: drive request (link_index, bandwidth) and raise start;
//   the request is taken at a rising edge where start is high and busy low.
//   The bandwidth is written into the link table on that edge; busy then
//   stays high until the whole rescale has run.
//   Result channel: when the recomputed weight set differs from the stored
//   one, NUM_LINKS results come out on consecutive cycles in link order,
//   each marked by result_strobe for one cycle, last set on the final one.
//   If nothing changed, no result comes out. The receiver cannot stall:
//   each result is taken at the edge that ends its strobe cycle.
//   Config port: cfg_we/cfg_addr/cfg_wdata write max_weight or min_weight,
//   selected by cfg_addr; write them only while busy is low.
//   Sequence: a scan for the maximum (one link per cycle), then one divide
//   for the divisor and one per link, all on the single shared radix-2
//   divider. One request at a time.
//   Reset: synchronous; bandwidths clear to zero, stored weights to one,
//   max_weight to 16, min_weight to 1, sequencer idle.
`timescale 1ns / 1ps
`default_nettype none
module link_weight_rescaler_core
  import lwr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire lwr_request_t          request,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  output logic                       result_strobe,
  output lwr_result_t                result
);

  // config registers
  logic [CFG_W-1:0] max_weight;
  logic [CFG_W-1:0] min_weight;

  // link tables
  logic [BW_W-1:0]     bw_table     [NUM_LINKS];
  logic [WEIGHT_W-1:0] weight_table [NUM_LINKS];
  logic [WEIGHT_W-1:0] fresh_table  [NUM_LINKS];

  // sequencer
  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  pc_next;
  logic [IDX_W-1:0] idx;
  lwr_uword_t       uword;
  logic             jump;
  logic             idx_last;
  logic             accept;

  // datapath
  logic [BW_W-1:0]     top;
  logic [BW_W-1:0]     divisor;
  logic                changed;
  logic [BW_W-1:0]     scale;
  logic                div_start;
  logic [BW_W-1:0]     div_dividend;
  logic [BW_W-1:0]     div_divisor;
  logic                div_busy;
  logic [BW_W-1:0]     div_quotient;
  logic [WEIGHT_W-1:0] w_fresh;

  assign accept   = start && !busy;
  assign uword    = ucode_rom(pc);
  assign idx_last = (idx == IDX_W'(NUM_LINKS - 1));

  // zero max_weight acts as one
  assign scale = (max_weight == '0) ? BW_W'(1) : BW_W'(max_weight);

  always_comb begin
    case (uword.cond)
      C_NEXT:      jump = 1'b0;
      C_NOT_LAST:  jump = !idx_last;
      C_DIV_BUSY:  jump = div_busy;
      C_UNCHANGED: jump = !changed;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    if (accept) begin
      pc_next = PC_MAX;
    end else if (jump) begin
      pc_next = uword.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // divider operand select
  assign div_start    = busy && (uword.op == OP_DIV_TOP || uword.op == OP_DIV_LINK);
  assign div_dividend = (uword.op == OP_DIV_TOP) ? top : bw_table[idx];
  assign div_divisor  = (uword.op == OP_DIV_TOP) ? scale : divisor;

  lwr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // zero weight -> min_weight, large weight saturates
  always_comb begin
    if (div_quotient == '0) begin
      w_fresh = WEIGHT_W'(min_weight);
    end else if (div_quotient > BW_W'(WEIGHT_SAT)) begin
      w_fresh = WEIGHT_SAT;
    end else begin
      w_fresh = div_quotient[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_weight <= MAX_WEIGHT_RESET;
      min_weight <= MIN_WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_WEIGHT: max_weight <= cfg_wdata;
        REG_MIN_WEIGHT: min_weight <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_MAX;
      idx  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      pc   <= pc_next;
      idx  <= '0;
    end else if (busy) begin
      pc <= pc_next;
      if (uword.op == OP_END) begin
        busy <= 1'b0;
      end
      // loop ops step the link index, wrapping to zero after the last link
      if (uword.op == OP_MAX || uword.op == OP_WSTORE || uword.op == OP_EMIT) begin
        idx <= idx_last ? '0 : idx + IDX_W'(1);
      end
    end
  end

  // tables with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LINKS; i++) begin
        bw_table[i]     <= '0;
        weight_table[i] <= WEIGHT_W'(1);
      end
    end else begin
      if (accept && ({1'b0, request.link_index} < (LINK_W + 1)'(NUM_LINKS))) begin
        bw_table[request.link_index[IDX_W-1:0]] <= request.bandwidth;
      end
      if (busy && uword.op == OP_EMIT) begin
        weight_table[idx] <= fresh_table[idx];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      top <= '0;
    end else if (busy && uword.op == OP_MAX && bw_table[idx] > top) begin
      top <= bw_table[idx];
    end
    if (busy && uword.op == OP_SETDIV) begin
      divisor <= (div_quotient == '0) ? BW_W'(1) : div_quotient;
    end
    if (busy && uword.op == OP_WSTORE) begin
      fresh_table[idx] <= w_fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
    end else if (busy && uword.op == OP_SETDIV) begin
      changed <= 1'b0;
    end else if (busy && uword.op == OP_WSTORE && w_fresh != weight_table[idx]) begin
      changed <= 1'b1;
    end
  end

  // registered result port
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= busy && (uword.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (busy && uword.op == OP_EMIT) begin
      result.out_link <= LINK_W'(idx);
      result.weight   <= fresh_table[idx];
      result.last     <= idx_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lwr_divider.sv @@
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on lwr_pkg (BW_W).
`timescale 1ns / 1ps
`default_nettype none
module lwr_divider
  import lwr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [BW_W-1:0] dividend,
  input  wire logic [BW_W-1:0] divisor,
  output logic                 busy,
  output logic [BW_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(BW_W + 1);

  logic [BW_W-1:0]  rem;
  logic [BW_W-1:0]  quo;
  logic [BW_W-1:0]  dsr;
  logic [CNT_W-1:0] count;
  logic [BW_W+1:0]  trial;

  // shift in next dividend bit, try subtract
  assign trial = {1'b0, rem, quo[BW_W-1]} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(BW_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[BW_W+1]) begin
        rem <= trial[BW_W-1:0];
        quo <= {quo[BW_W-2:0], 1'b1};
      end else begin
        rem <= {rem[BW_W-2:0], quo[BW_W-1]};
        quo <= {quo[BW_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

@@ rtl/lwr_checker.sv @@
// Port-level checks for link_weight_rescaler_core, bound to the top level.
// Depends on lwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lwr_checker
  import lwr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  cfg_we,
  input wire logic                  result_strobe,
  input wire lwr_result_t           result
);

  // accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  // results only come out while a request is in progress
  a_result_in_request: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result strobe while idle");

  // a schedule is emitted without gaps up to its last entry
  a_schedule_burst: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last) |=>
      (result_strobe && result.out_link == $past(result.out_link) + LINK_W'(1)))
    else $error("gap or out-of-order link in schedule");

  // no strobe directly follows the last entry
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |=> !result_strobe)
    else $error("result after last entry");

  // registers are only written while no request is in progress
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !busy)
    else $error("register write while busy");

endmodule

bind link_weight_rescaler_core lwr_checker u_lwr_checker (.*);
`default_nettype wire
